@@ src/rtb_pkg.sv @@
`timescale 1ns / 1ps

package rtb_pkg;

  localparam int MAX_PREFIX_LEN  = 12;
  localparam int KEY_W           = 64;
  localparam int POS_W           = 32;
  localparam int VALUE_W         = 32;
  localparam int IDX_W           = 13;
  localparam int MODE_W          = 2;
  localparam int PREFIX_W        = 4;
  localparam int STORE_DEPTH     = (1 << MAX_PREFIX_LEN) + 1;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 4'd8;

  // Register index within the configuration map.
  localparam logic REG_PREFIX_LEN = 1'b0;

  // Item operation codes.
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_NEWB,
    ST_FILL,
    ST_READ,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic clr_write;
    logic latch_in;
    logic new_build;
    logic key_step;
    logic fin_step;
    logic fill_write;
    logic rd_issue;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic              clr_last;
    logic [MODE_W-1:0] mode;
    logic              done;
    logic              bucket_differs;
    logic              fin_nonempty;
    logic              fill_last;
    logic              out_free;
  } status_t;

endpackage

@@ src/rtb_in_if.sv @@
`timescale 1ns / 1ps

interface rtb_in_if import rtb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  key;
  logic [IDX_W-1:0]  entry_index;

  modport source(output valid, mode, key, entry_index, input ready);
  modport sink(input valid, mode, key, entry_index, output ready);
endinterface

@@ src/rtb_out_if.sv @@
`timescale 1ns / 1ps

interface rtb_out_if import rtb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] entry_value;
  logic [VALUE_W-1:0] key_count;

  modport source(output valid, entry_value, key_count, input ready);
  modport sink(input valid, entry_value, key_count, output ready);
endinterface

@@ src/rtb_ctrl.sv @@
`timescale 1ns / 1ps

module rtb_ctrl import rtb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        case (status_i.mode)
          MODE_ADD: begin
            if (status_i.done) begin
              state_d = ST_NEWB;
            end else if (status_i.bucket_differs) begin
              state_d = ST_FILL;
            end else begin
              state_d = ST_RESULT;
            end
          end
          MODE_FINISH: begin
            state_d = status_i.fin_nonempty ? ST_FILL : ST_RESULT;
          end
          MODE_READ: state_d = ST_READ;
          default:   state_d = ST_RESULT;
        endcase
      end
      // After the new-build cleanup the key is handled as in any open build.
      ST_NEWB: state_d = ST_EXEC;
      ST_FILL: begin
        if (status_i.fill_last) state_d = ST_RESULT;
      end
      ST_READ: state_d = ST_RESULT;
      ST_RESULT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_write = 1'b1;
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      ST_EXEC: begin
        case (status_i.mode)
          MODE_ADD:    cmd_o.key_step = !status_i.done;
          MODE_FINISH: cmd_o.fin_step = 1'b1;
          MODE_READ:   cmd_o.rd_issue = 1'b1;
          default:     cmd_o = '0;
        endcase
      end
      ST_NEWB:   cmd_o.new_build  = 1'b1;
      ST_FILL:   cmd_o.fill_write = 1'b1;
      ST_READ:   cmd_o = '0;
      ST_RESULT: cmd_o.load_out   = status_i.out_free;
      default:   cmd_o = '0;
    endcase
  end

endmodule

@@ src/rtb_dp.sv @@
`timescale 1ns / 1ps

module rtb_dp import rtb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [PREFIX_W-1:0] prefix_len_i,
  input  logic [MODE_W-1:0]   in_mode_i,
  input  logic [KEY_W-1:0]    in_key_i,
  input  logic [IDX_W-1:0]    in_entry_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [VALUE_W-1:0]  out_entry_value_o,
  output logic [VALUE_W-1:0]  out_key_count_o
);

  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(STORE_DEPTH - 1);

  logic [VALUE_W-1:0] table_mem [STORE_DEPTH];

  logic [IDX_W-1:0]          clr_ptr_q;
  logic [MODE_W-1:0]         mode_q;
  logic [MAX_PREFIX_LEN-1:0] key_top_q;
  logic [IDX_W-1:0]          idx_q;
  logic [MAX_PREFIX_LEN-1:0] prev_q;
  logic [POS_W-1:0]          pos_q;
  logic                      done_q;
  logic [IDX_W-1:0]          ptr_q;
  logic [IDX_W-1:0]          end_q;
  logic [VALUE_W-1:0]        fill_val_q;
  logic [VALUE_W-1:0]        rdata_q;
  logic                      out_valid_q;
  logic [VALUE_W-1:0]        out_value_q;
  logic [VALUE_W-1:0]        out_count_q;

  logic [PREFIX_W-1:0]       pb_eff;
  logic [MAX_PREFIX_LEN-1:0] bucket;
  logic [IDX_W-1:0]          top;
  logic [IDX_W-1:0]          prev_next;
  logic [POS_W-1:0]          pos_inc;
  logic                      idx_ok;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [VALUE_W-1:0]        mem_wdata;
  logic                      out_free;

  // A prefix of zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (prefix_len_i == '0) begin
      pb_eff = PREFIX_W'(1);
    end else if (prefix_len_i > PREFIX_W'(MAX_PREFIX_LEN)) begin
      pb_eff = PREFIX_W'(MAX_PREFIX_LEN);
    end else begin
      pb_eff = prefix_len_i;
    end
  end

  assign bucket    = key_top_q >> (PREFIX_W'(MAX_PREFIX_LEN) - pb_eff);
  assign top       = IDX_W'(1) << pb_eff;
  assign prev_next = {1'b0, prev_q} + IDX_W'(1);
  assign pos_inc   = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);
  assign idx_ok    = idx_q <= LAST_ENTRY;
  assign out_free  = !out_valid_q || out_ready_i;

  // Single write port shared by the reset sweep, the new-build cleanup and gap fills.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = fill_val_q;
    if (cmd_i.clr_write) begin
      mem_we    = 1'b1;
      mem_waddr = clr_ptr_q;
      mem_wdata = '0;
    end else if (cmd_i.new_build) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = '0;
    end else if (cmd_i.fill_write) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_issue && idx_ok) begin
      rdata_q <= table_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
    end else if (cmd_i.clr_write && clr_ptr_q != LAST_ENTRY) begin
      clr_ptr_q <= clr_ptr_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      mode_q    <= in_mode_i;
      key_top_q <= in_key_i[KEY_W-1 -: MAX_PREFIX_LEN];
      idx_q     <= in_entry_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pos_q  <= '0;
      done_q <= 1'b0;
    end else if (cmd_i.new_build) begin
      prev_q <= '0;
      pos_q  <= '0;
      done_q <= 1'b0;
    end else if (cmd_i.key_step) begin
      prev_q <= bucket;
      pos_q  <= pos_inc;
    end else if (cmd_i.fin_step) begin
      done_q <= 1'b1;
    end
  end

  // An unsorted bucket below the previous one writes only its own entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_step) begin
      ptr_q      <= (bucket > prev_q) ? prev_next : {1'b0, bucket};
      end_q      <= {1'b0, bucket};
      fill_val_q <= VALUE_W'(pos_q);
    end else if (cmd_i.fin_step) begin
      ptr_q      <= prev_next;
      end_q      <= top;
      fill_val_q <= VALUE_W'(pos_q);
    end else if (cmd_i.fill_write) begin
      ptr_q <= ptr_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_value_q <= (mode_q == MODE_READ && idx_ok) ? rdata_q : '0;
      out_count_q <= VALUE_W'(pos_q);
    end
  end

  assign status_o.clr_last       = clr_ptr_q == LAST_ENTRY;
  assign status_o.mode           = mode_q;
  assign status_o.done           = done_q;
  assign status_o.bucket_differs = bucket != prev_q;
  assign status_o.fin_nonempty   = {1'b0, prev_q} < top;
  assign status_o.fill_last      = ptr_q == end_q;
  assign status_o.out_free       = out_free;

  assign out_valid_o       = out_valid_q;
  assign out_entry_value_o = out_value_q;
  assign out_key_count_o   = out_count_q;

endmodule

@@ src/radix_table_builder.sv @@
`timescale 1ns / 1ps

// Radix table builder. After reset the block sweeps its 4097-entry table to zero,
// one entry per cycle, and accepts no item until the sweep is done; configuration
// writes are taken throughout. Items are handled one at a time. An add-key item
// whose bucket matches the previous one goes straight to its result; a key that
// moves to a new bucket first fills the gap one entry at a time, since the table
// memory has a single write port. The first key after a finish rewrites entry 0
// and then evaluates the key again. A finish item fills the entries up to the
// sentinel one at a time. While the previous result has not been taken, the
// block holds in its result state until the output register frees up; a finished
// result then waits there while the next item is taken in. The prefix length may
// only be written while no item is in flight.
module radix_table_builder import rtb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rtb_in_if.sink                in_i,
  rtb_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [PREFIX_W-1:0] prefix_len_q;
  logic                reg_sel;
  cmd_t                cmd;
  status_t             status;
  logic                in_ready;

  assign reg_sel = paddr[APB_ADDR_W-1] == REG_PREFIX_LEN;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(prefix_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_len_q <= PREFIX_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      prefix_len_q <= pwdata[PREFIX_W-1:0];
    end
  end

  assign in_i.ready = in_ready;

  rtb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rtb_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .prefix_len_i      (prefix_len_q),
    .in_mode_i         (in_i.mode),
    .in_key_i          (in_i.key),
    .in_entry_index_i  (in_i.entry_index),
    .out_valid_o       (out_o.valid),
    .out_ready_i       (out_o.ready),
    .out_entry_value_o (out_o.entry_value),
    .out_key_count_o   (out_o.key_count)
  );

endmodule

@@ verif/tb_radix_table_builder.sv @@
`timescale 1ns / 1ps

module tb_radix_table_builder import rtb_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int PHASE_ITEMS    = 108;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [PREFIX_W-1:0] PREFIX_PLAN [16] =
    '{4'd1, 4'd12, 4'd0, 4'd15, 4'd2, 4'd5, 4'd3, 4'd9,
      4'd4, 4'd10, 4'd6, 4'd7, 4'd11, 4'd13, 4'd14, 4'd8};

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  entry_index;
  } lookup_item_t;

  typedef struct {
    logic [VALUE_W-1:0] entry_value;
    logic [VALUE_W-1:0] key_count;
  } lookup_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rtb_in_if  in_bus ();
  rtb_out_if out_bus ();

  radix_table_builder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the block's state.
  logic [POS_W-1:0]    expected_table [STORE_DEPTH] = '{default: '0};
  int                  last_bucket  = 0;
  logic [POS_W-1:0]    key_total    = '0;
  logic                build_closed = 1'b0;
  logic [PREFIX_W-1:0] cfg_prefix   = PREFIX_RESET;

  lookup_item_t   queued_items [$];
  lookup_result_t pending_results [$];
  lookup_item_t   next_item;
  lookup_result_t oldest_result;
  int             items_queued   = 0;
  int             error_count    = 0;
  int             src_idle_pct   = 0;
  int             sink_stall_pct = 0;
  int             idle_cycles    = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int active_prefix(input logic [PREFIX_W-1:0] value);
    if (value == 0) return 1;
    if (value > MAX_PREFIX_LEN) return MAX_PREFIX_LEN;
    return int'(value);
  endfunction

  task automatic compute_lookup_result(input lookup_item_t it);
    int             pb;
    int             bucket;
    lookup_result_t res;
    pb = active_prefix(cfg_prefix);
    res.entry_value = '0;
    case (it.mode)
      MODE_ADD: begin
        if (build_closed) begin
          last_bucket = 0;
          key_total = '0;
          expected_table[0] = '0;
          build_closed = 1'b0;
        end
        bucket = int'(it.key >> (KEY_W - pb));
        // A bucket below the last one writes only its own entry.
        if (bucket != last_bucket) begin
          for (int i = last_bucket + 1; i < bucket; i++) expected_table[i] = key_total;
          expected_table[bucket] = key_total;
          last_bucket = bucket;
        end
        if (key_total != '1) key_total = key_total + 1'b1;
      end
      MODE_FINISH: begin
        for (int i = last_bucket + 1; i <= (1 << pb); i++) expected_table[i] = key_total;
        build_closed = 1'b1;
      end
      MODE_READ: begin
        if (it.entry_index < STORE_DEPTH) res.entry_value = expected_table[it.entry_index];
      end
      default: ;
    endcase
    res.key_count = key_total;
    pending_results = {pending_results, res};
  endtask

  function automatic void queue_item(input logic [MODE_W-1:0] mode,
                                     input logic [KEY_W-1:0] key,
                                     input logic [IDX_W-1:0] entry_index);
    lookup_item_t it;
    it.mode = mode;
    it.key = key;
    it.entry_index = entry_index;
    queued_items = {queued_items, it};
    items_queued++;
  endfunction

  function automatic logic [IDX_W-1:0] pick_entry_index(input int pb);
    case ($urandom_range(0, 9))
      0: return IDX_W'($urandom);
      1, 2: return IDX_W'($urandom_range(0, STORE_DEPTH - 1));
      default: return IDX_W'($urandom_range(0, (1 << pb) + 1));
    endcase
  endfunction

  // One build: a run of sorted keys with a few out of order and reads among them, then
  // usually a finish (now and then two), some reads and at times an unused-mode item.
  task automatic queue_build(input int pb);
    logic [KEY_W-1:0] cursor;
    logic [KEY_W-1:0] step;
    logic [KEY_W-1:0] key;
    logic             carry;
    int               n_keys;
    n_keys = $urandom_range(1, 40);
    cursor = {$urandom, $urandom} >> $urandom_range(0, pb + 2);
    for (int k = 0; k < n_keys; k++) begin
      if ($urandom_range(0, 24) == 0) begin
        key = {$urandom, $urandom};
      end else begin
        case ($urandom_range(0, 7))
          0: step = '0;
          1, 2, 3, 4: step = {$urandom, $urandom} >> $urandom_range(pb + 1, 64);
          default: step = {$urandom, $urandom} >> $urandom_range(pb > 3 ? pb - 3 : 0, pb);
        endcase
        {carry, cursor} = {1'b0, cursor} + {1'b0, step};
        if (carry) cursor = '1;
        key = cursor;
      end
      queue_item(MODE_ADD, key, IDX_W'($urandom));
      if ($urandom_range(0, 5) == 0) begin
        queue_item(MODE_READ, {$urandom, $urandom}, pick_entry_index(pb));
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      queue_item(MODE_FINISH, {$urandom, $urandom}, IDX_W'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        queue_item(MODE_FINISH, {$urandom, $urandom}, IDX_W'($urandom));
      end
    end
    repeat ($urandom_range(1, 5)) begin
      queue_item(MODE_READ, {$urandom, $urandom}, pick_entry_index(pb));
    end
    if ($urandom_range(0, 9) == 0) begin
      queue_item(MODE_UNUSED, {$urandom, $urandom}, IDX_W'($urandom));
    end
  endtask

  task automatic apb_transfer(input logic write, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= APB_ADDR_W'(4 * REG_PREFIX_LEN);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_prefix_readback(input logic [PREFIX_W-1:0] value);
    logic [APB_DATA_W-1:0] rdata;
    apb_transfer(1'b0, '0, rdata);
    if (rdata[PREFIX_W-1:0] !== value) begin
      $display("%0t ns: prefix length readback mismatch: expected %0d, actual %0d",
               $time, value, rdata[PREFIX_W-1:0]);
      error_count++;
    end
  endtask

  // Returns once every queued item has been taken and every result has arrived.
  task automatic wait_idle();
    while (queued_items.size() != 0 || in_bus.valid || pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid       <= 1'b0;
      in_bus.mode        <= MODE_ADD;
      in_bus.key         <= '0;
      in_bus.entry_index <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        next_item.mode = in_bus.mode;
        next_item.key = in_bus.key;
        next_item.entry_index = in_bus.entry_index;
        compute_lookup_result(next_item);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (queued_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          next_item = queued_items.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.mode        <= next_item.mode;
          in_bus.key         <= next_item.key;
          in_bus.entry_index <= next_item.entry_index;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected: entry_value %0d, key_count %0d",
                   $time, out_bus.entry_value, out_bus.key_count);
          error_count++;
        end else begin
          oldest_result = pending_results.pop_front();
          if (out_bus.entry_value !== oldest_result.entry_value) begin
            $display("%0t ns: entry_value mismatch: expected %0d, actual %0d",
                     $time, oldest_result.entry_value, out_bus.entry_value);
            error_count++;
          end
          if (out_bus.key_count !== oldest_result.key_count) begin
            $display("%0t ns: key_count mismatch: expected %0d, actual %0d",
                     $time, oldest_result.key_count, out_bus.key_count);
            error_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Counts cycles in which neither side completes a transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [APB_DATA_W-1:0] rdata;
    int                    phase_start;
    int                    pb;
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_prefix_readback(PREFIX_RESET);

    // Directed items at the reset prefix of 8 bits.
    queue_item(MODE_READ, '0, 13'd0);
    queue_item(MODE_READ, '1, 13'd4096);
    queue_item(MODE_READ, '0, 13'd4097);
    queue_item(MODE_READ, '1, 13'd8191);
    queue_item(MODE_ADD, 64'h0000_0000_0000_0000, 13'd0);
    queue_item(MODE_ADD, 64'h0100_0000_0000_0000, 13'h1FFF);
    queue_item(MODE_ADD, 64'h01FF_FFFF_FFFF_FFFF, 13'd0);
    queue_item(MODE_ADD, 64'h0500_0000_0000_0000, 13'd0);
    // Out of order: lands in a lower bucket than the last key.
    queue_item(MODE_ADD, 64'h0280_0000_0000_0000, 13'd0);
    queue_item(MODE_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 13'd0);
    queue_item(MODE_FINISH, '1, 13'h1FFF);
    queue_item(MODE_FINISH, '0, 13'd0);
    queue_item(MODE_READ, '0, 13'd1);
    queue_item(MODE_READ, '0, 13'd5);
    queue_item(MODE_READ, '0, 13'd255);
    queue_item(MODE_READ, '0, 13'd256);
    queue_item(MODE_READ, '0, 13'd257);
    queue_item(MODE_UNUSED, '1, 13'h1FFF);
    // The first key after a finish opens a new build.
    queue_item(MODE_ADD, 64'h8000_0000_0000_0000, 13'd0);
    queue_item(MODE_READ, '0, 13'd0);
    queue_item(MODE_FINISH, '0, 13'd0);
    queue_item(MODE_READ, '0, 13'd129);

    for (int phase = 0; phase < 16; phase++) begin
      wait_idle();
      case (phase % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 62;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 62;
        end
        default: begin
          src_idle_pct = 33;
          sink_stall_pct = 33;
        end
      endcase
      apb_transfer(1'b1, APB_DATA_W'(PREFIX_PLAN[phase]), rdata);
      cfg_prefix = PREFIX_PLAN[phase];
      check_prefix_readback(PREFIX_PLAN[phase]);
      pb = active_prefix(PREFIX_PLAN[phase]);
      phase_start = items_queued;
      while (items_queued - phase_start < PHASE_ITEMS) queue_build(pb);
    end

    wait_idle();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
